// File: rtl/tlf_pkg.sv
// shared constants and types for the text line folder
`default_nettype none

package tlf_pkg;

    // word store depth default
    localparam int WORD_DEPTH_DEF = 32;

    // line width register
    localparam logic [7:0] LINE_WIDTH_RST = 8'd80;
    localparam logic [7:0] LINE_WIDTH_MIN = 8'd8;

    // special characters
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_HYPHEN = 8'd45;

    // tab stops fall on multiples of this
    localparam logic [7:0] TAB_STEP = 8'd8;

    // request to the shared column unit
    typedef struct packed {
        logic       tab_base;   // round column down to a tab stop first
        logic [7:0] addend;
    } t_col_op;

    // answer from the shared column unit
    typedef struct packed {
        logic [8:0] sum;
        logic       gt_w;       // sum above the line width
        logic       ge_w;       // sum at or above the line width
    } t_col_res;

endpackage

`default_nettype wire

// File: rtl/tlf_if.sv
// valid/ready channel interfaces for input and output items
`default_nettype none

interface tlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;
    logic       word_truncated;

    modport source (output valid, output char_out, output last, output word_truncated,
                     input ready);
    modport sink   (input valid, input char_out, input last, input word_truncated,
                     output ready);
endinterface

`default_nettype wire

// File: rtl/tlf_word_mem.sv
// word store: one write port, one registered read port
`default_nettype none

module tlf_word_mem #(
    parameter int DEPTH = tlf_pkg::WORD_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/tlf_col_unit.sv
// shared column adder and line width comparator
`default_nettype none

module tlf_col_unit (
    input  wire logic [7:0]      i_col,
    input  wire logic [7:0]      i_width,
    input  wire tlf_pkg::t_col_op i_op,
    output tlf_pkg::t_col_res    o_res
);

    logic [7:0] base;
    logic [8:0] sum;

    // base column, optionally snapped down to a tab stop
    always_comb begin
        if (i_op.tab_base) begin
            base = i_col & ~(tlf_pkg::TAB_STEP - 8'd1);
        end else begin
            base = i_col;
        end
        sum = {1'b0, base} + {1'b0, i_op.addend};
    end

    // compare against the line width
    assign o_res.sum  = sum;
    assign o_res.gt_w = (sum > {1'b0, i_width});
    assign o_res.ge_w = (sum >= {1'b0, i_width});

endmodule

`default_nettype wire

// File: rtl/text_line_folder.sv
// text line folder top level: word gathering and flush sequencer
//
// Input items arrive on i_in (one text byte each), output items leave on
// o_out (one byte each, with last and word_truncated). Bytes other than
// space, tab and newline are written to the word store, one per cycle
// while it has room (later ones are dropped and set word_truncated), and
// give no output item. A delimiter starts a flush: the sequencer walks
// the store one byte per cycle through the registered read port,
// inserting a wrap newline or hyphen/newline/hyphen breaks, then sends
// the delimiter and possibly a trailing newline, paced by the single
// column adder/comparator and the output register. An accepted delimiter
// sets r_state; the first flush state then loads the output register.
// i_in.ready is low for the whole flush. When the receiver stalls, the
// sequencer holds in place until the output register frees up.
// The line width is written through i_cfg_we/i_cfg_wdata; write it only
// while idle, as the block itself does not enforce this; values below 8
// are taken as 8. Synchronous active-low reset returns to idle with an
// empty word, column 0 and a line width of 80; the store contents are
// not cleared, only its length.
`default_nettype none

module text_line_folder #(
    parameter int WORD_DEPTH = tlf_pkg::WORD_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tlf_in_if.sink          i_in,
    tlf_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    localparam int AW = $clog2(WORD_DEPTH);
    localparam int LW = $clog2(WORD_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NL_PRE,
        S_WORD,
        S_SPLIT,
        S_BRK_NL,
        S_BRK_HY,
        S_DELIM,
        S_NL_POST
    } t_state;

    t_state     r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_idx, n_idx;
    logic [7:0] r_col, n_col;
    logic       r_ovf, n_ovf;
    logic       r_flag, n_flag;
    logic [7:0] r_delim, n_delim;
    logic [7:0] r_width;

    logic       r_ov;
    logic [7:0] r_och;
    logic       r_olast;
    logic       r_otr;

    logic       slot;
    logic       in_acc;
    logic       is_delim;
    logic       emit;
    logic [7:0] e_ch;
    logic       e_last;
    logic       mem_we;
    logic [7:0] rd_data;
    logic [7:0] len_ext;
    logic [LW-1:0] idx_inc;

    tlf_pkg::t_col_op  col_op;
    tlf_pkg::t_col_res col_res;

    // word store
    tlf_word_mem #(
        .DEPTH (WORD_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_in.char_in),
        .i_raddr (n_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // shared column arithmetic
    tlf_col_unit u_col (
        .i_col   (r_col),
        .i_width (r_width),
        .i_op    (col_op),
        .o_res   (col_res)
    );

    // handshake helpers
    assign slot     = !r_ov || o_out.ready;
    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign is_delim = (i_in.char_in == tlf_pkg::CH_SPACE) ||
                      (i_in.char_in == tlf_pkg::CH_TAB) ||
                      (i_in.char_in == tlf_pkg::CH_NL);
    assign len_ext  = 8'(r_len);
    assign idx_inc  = r_idx + LW'(1);

    // flush sequencer
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_idx   = r_idx;
        n_col   = r_col;
        n_ovf   = r_ovf;
        n_flag  = r_flag;
        n_delim = r_delim;
        emit    = 1'b0;
        e_ch    = tlf_pkg::CH_NL;
        e_last  = 1'b0;
        mem_we  = 1'b0;
        col_op  = '{tab_base: 1'b0, addend: 8'd1};
        case (r_state)
            S_IDLE: begin
                col_op.addend = len_ext;
                if (in_acc) begin
                    if (!is_delim) begin
                        if (r_len < LW'(WORD_DEPTH)) begin
                            mem_we = 1'b1;
                            n_len  = r_len + LW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_delim = i_in.char_in;
                        n_flag  = r_ovf;
                        n_ovf   = 1'b0;
                        n_idx   = '0;
                        if (len_ext >= r_width) begin
                            n_state = S_SPLIT;
                        end else if (col_res.gt_w) begin
                            n_state = S_NL_PRE;
                        end else if (r_len == '0) begin
                            n_state = S_DELIM;
                        end else begin
                            n_state = S_WORD;
                        end
                    end
                end
            end
            S_NL_PRE: begin
                if (slot) begin
                    emit  = 1'b1;
                    e_ch  = tlf_pkg::CH_NL;
                    n_col = 8'd0;
                    if (r_len == '0) begin
                        n_state = S_DELIM;
                    end else begin
                        n_state = S_WORD;
                    end
                end
            end
            S_WORD: begin
                if (slot) begin
                    emit  = 1'b1;
                    e_ch  = rd_data;
                    n_col = col_res.sum[7:0];
                    n_idx = idx_inc;
                    if (idx_inc == r_len) begin
                        n_state = S_DELIM;
                    end
                end
            end
            S_SPLIT: begin
                if (slot) begin
                    emit = 1'b1;
                    if (!col_res.gt_w) begin
                        e_ch  = rd_data;
                        n_col = col_res.sum[7:0];
                        n_idx = idx_inc;
                        if (idx_inc == r_len) begin
                            n_state = S_DELIM;
                        end
                    end else begin
                        e_ch    = tlf_pkg::CH_HYPHEN;
                        n_state = S_BRK_NL;
                    end
                end
            end
            S_BRK_NL: begin
                if (slot) begin
                    emit    = 1'b1;
                    e_ch    = tlf_pkg::CH_NL;
                    n_state = S_BRK_HY;
                end
            end
            S_BRK_HY: begin
                if (slot) begin
                    emit    = 1'b1;
                    e_ch    = tlf_pkg::CH_HYPHEN;
                    n_col   = 8'd1;
                    n_state = S_SPLIT;
                end
            end
            S_DELIM: begin
                col_op.tab_base = (r_delim == tlf_pkg::CH_TAB);
                col_op.addend   = (r_delim == tlf_pkg::CH_TAB) ? tlf_pkg::TAB_STEP : 8'd1;
                if (slot) begin
                    emit  = 1'b1;
                    e_ch  = r_delim;
                    n_len = '0;
                    if (r_delim == tlf_pkg::CH_NL) begin
                        n_col   = 8'd0;
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end else if (col_res.ge_w) begin
                        n_col   = 8'd0;
                        n_state = S_NL_POST;
                    end else begin
                        n_col   = col_res.sum[7:0];
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_NL_POST: begin
                if (slot) begin
                    emit    = 1'b1;
                    e_ch    = tlf_pkg::CH_NL;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_idx   <= '0;
            r_col   <= 8'd0;
            r_ovf   <= 1'b0;
            r_flag  <= 1'b0;
            r_width <= tlf_pkg::LINE_WIDTH_RST;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_col   <= n_col;
            r_ovf   <= n_ovf;
            r_flag  <= n_flag;
            if (i_cfg_we) begin
                r_width <= (i_cfg_wdata < tlf_pkg::LINE_WIDTH_MIN) ?
                           tlf_pkg::LINE_WIDTH_MIN : i_cfg_wdata;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
        r_delim <= n_delim;
        if (emit) begin
            r_och   <= e_ch;
            r_olast <= e_last;
            r_otr   <= r_flag;
        end
    end

    // port drive
    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ov;
    assign o_out.char_out       = r_och;
    assign o_out.last           = r_olast;
    assign o_out.word_truncated = r_otr;

endmodule

`default_nettype wire

// File: rtl/tlf_checker.sv
// port-level checks for the text line folder, bound to the top level
`default_nettype none

module tlf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [7:0] i_char_in,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_char_out,
    input wire logic       i_out_last
);

    logic in_delim;

    assign in_delim = (i_char_in == tlf_pkg::CH_SPACE) ||
                      (i_char_in == tlf_pkg::CH_TAB) ||
                      (i_char_in == tlf_pkg::CH_NL);

    // a delimiter starts a flush, so input closes at once
    a_delim_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && in_delim) |=> !i_in_ready)
        else $error("input still ready after a delimiter item");

    // a word byte produces no output item
    a_word_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !in_delim && !i_out_valid) |=> !i_out_valid)
        else $error("output item appeared for a word byte");

    // while a non-final item waits, the flush is still running
    a_flush_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input ready before the final item of a flush");

    // stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_char_out) && $stable(i_out_last)))
        else $error("stalled output item changed");

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_char_in   (i_in.char_in),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_char_out  (o_out.char_out),
    .i_out_last  (o_out.last)
);

`default_nettype wire
